// ===== rtl/acs_pkg.sv =====
`timescale 1ns / 1ps

package acs_pkg;

  // Default depth of both the instruction store and the data store.
  localparam int STORE_DEPTH_DEFAULT = 32;

  // Field widths of one instruction byte.
  localparam int OPCODE_W  = 3;
  localparam int OPERAND_W = 5;
  localparam int WORD_W    = 8;

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Opcodes.
  localparam logic [OPCODE_W-1:0] OP_MOV  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_JP   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_JPZ  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_LOAD = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_STR  = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_HLT  = 3'd7;

  // One command beat.
  typedef struct packed {
    logic                 command;
    logic [OPERAND_W-1:0] address;
    logic [WORD_W-1:0]    data;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic [OPERAND_W-1:0] pc;
    logic [WORD_W-1:0]    accum;
    logic [OPCODE_W-1:0]  opcode;
    logic                 halted;
    logic                 stored;
    logic [WORD_W-1:0]    stored_value;
  } res_t;

endpackage

// ===== rtl/acs_core.sv =====
`timescale 1ns / 1ps

module acs_core #(
  parameter int STORE_DEPTH = acs_pkg::STORE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  acs_pkg::cmd_t item,
  output acs_pkg::res_t result
);
  import acs_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int NUM_OPERANDS = 1 << OPERAND_W;

  // Reduction of every 5-bit operand modulo the store depth, built at elaboration.
  function automatic logic [NUM_OPERANDS*AW-1:0] build_wrap_tbl();
    logic [NUM_OPERANDS*AW-1:0] tbl;
    tbl = '0;
    for (int i = 0; i < NUM_OPERANDS; i++) begin
      tbl[i*AW +: AW] = AW'(i % STORE_DEPTH);
    end
    return tbl;
  endfunction

  localparam logic [NUM_OPERANDS*AW-1:0] WRAP_TBL = build_wrap_tbl();
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);

  // Architectural state.
  logic [WORD_W-1:0] prog_mem [STORE_DEPTH];
  logic [WORD_W-1:0] data_mem [STORE_DEPTH];
  logic [AW-1:0]     pc;
  logic [WORD_W-1:0] acc;
  logic              halt;

  logic [AW-1:0]        pc_inc;
  logic [WORD_W-1:0]    instr;
  logic [OPCODE_W-1:0]  op;
  logic [AW-1:0]        operand_addr;
  logic [AW-1:0]        load_addr;
  logic [AW-1:0]        pc_next;
  logic [WORD_W-1:0]    acc_next;
  logic                 halt_next;
  logic                 store_en;
  logic [OPCODE_W-1:0]  op_out;
  logic                 prog_we;

  // Fetch from the advanced counter.
  assign pc_inc       = (pc == LAST_ADDR) ? '0 : pc + AW'(1);
  assign instr        = prog_mem[pc_inc];
  assign op           = instr[WORD_W-1 -: OPCODE_W];
  assign operand_addr = WRAP_TBL[instr[OPERAND_W-1:0]*AW +: AW];
  assign load_addr    = WRAP_TBL[item.address*AW +: AW];
  assign prog_we      = fire && (item.command == CMD_LOAD);

  // Execute one command against the current state.
  always_comb begin
    pc_next   = pc;
    acc_next  = acc;
    halt_next = halt;
    store_en  = 1'b0;
    op_out    = OP_MOV;
    if (item.command == CMD_STEP) begin
      if (halt) begin
        op_out = OP_HLT;
      end else begin
        op_out  = op;
        pc_next = pc_inc;
        unique case (op)
          OP_MOV:  acc_next = WORD_W'(instr[OPERAND_W-1:0]);
          OP_ADD:  acc_next = acc + WORD_W'(instr[OPERAND_W-1:0]);
          OP_SUB:  acc_next = acc - WORD_W'(instr[OPERAND_W-1:0]);
          OP_JP:   pc_next  = operand_addr;
          OP_JPZ: begin
            if (acc == '0) begin
              pc_next = operand_addr;
            end
          end
          OP_LOAD: acc_next = data_mem[operand_addr];
          OP_STR:  store_en = 1'b1;
          OP_HLT:  halt_next = 1'b1;
          default: halt_next = 1'b1;
        endcase
      end
    end
  end

  // Result of this command, reported from the post-command state.
  always_comb begin
    result.pc           = OPERAND_W'(pc_next);
    result.accum        = acc_next;
    result.opcode       = op_out;
    result.halted       = halt_next;
    result.stored       = store_en;
    result.stored_value = store_en ? acc : '0;
  end

  // Control state commits when the command executes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= '0;
      acc  <= '0;
      halt <= 1'b0;
    end else if (fire) begin
      pc   <= pc_next;
      acc  <= acc_next;
      halt <= halt_next;
    end
  end

  // Data store is cleared at reset and written by a store instruction.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        data_mem[i] <= '0;
      end
    end else if (fire && store_en) begin
      data_mem[operand_addr] <= acc;
    end
  end

  // Instruction store has no reset; entries are defined once loaded.
  always_ff @(posedge clk) begin
    if (prog_we) begin
      prog_mem[load_addr] <= item.data;
    end
  end

endmodule

// ===== rtl/accumulator_cpu_step.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Handshake           | Beat
// cmd     | in        | cmd_valid/cmd_stall | acs_pkg::cmd_t (command, address, data)
// res     | out       | res_valid/res_stall | acs_pkg::res_t (pc, accum, opcode, ...)
//
// One command per clock is sustained while the result is not stalled; each
// command passes from acceptance to its result beat through the input
// register, then execution into the result register. The processor state
// commits as a command leaves the input register. Reset clears the counter,
// accumulator, halt flag and the data store at once. A stalled result holds;
// cmd_stall rises only when both the input and result registers are full.
module accumulator_cpu_step #(
  parameter int STORE_DEPTH = acs_pkg::STORE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  acs_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output acs_pkg::res_t res
);
  import acs_pkg::*;

  logic  s1_valid;
  cmd_t  s1_item;
  logic  out_free;
  logic  s1_fire;
  res_t  core_result;

  // Pipeline flow control.
  assign out_free  = !res_valid || !res_stall;
  assign s1_fire   = s1_valid && out_free;
  assign cmd_stall = s1_valid && !out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!cmd_stall) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      s1_item <= cmd;
    end
  end

  // Execution unit and processor state.
  acs_core #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .fire  (s1_fire),
    .item  (s1_item),
    .result(core_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res <= core_result;
    end
  end

`ifndef SYNTHESIS
  // The input side is held back only while a command waits in the input register.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> s1_valid)
    else $error("cmd_stall raised with an empty input register");

  // An executed command always lands in the result register.
  a_fire_lands: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> res_valid)
    else $error("executed command produced no result beat");

  // Only a store instruction writes the data store, and never while halted.
  a_store_op: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.stored) |-> (res.opcode == OP_STR && !res.halted))
    else $error("store reported for a non-store or halted step");

  // A halt opcode is always reported with the halt flag set.
  a_halt_flag: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.opcode == OP_HLT) |-> res.halted)
    else $error("halt opcode without halt flag");
`endif

endmodule
